// ----- hdl/md5_pkg.sv -----
// Package for the MD5 digest unit: beat types, round constants, round helpers.
// No dependencies.
`default_nettype none
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
  } md5_out_t;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    BkIdle,
    BkRound,
    BkPad,
    BkOut
  } md5_bk_state_e;

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    begin
      unique case (r)
        6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
        6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
        6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
        6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
        6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    begin
      unique case ({r[5:4], r[1:0]})
        4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
        4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
        4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  // Message word index used by a round; the products are taken modulo 16.
  function automatic logic [3:0] word_sel(input logic [5:0] r);
    logic [3:0] g;
    logic [3:0] rl;
    begin
      rl = r[3:0];
      unique case (r[5:4])
        2'd0:    g = rl;
        2'd1:    g = 4'((rl << 2) + rl + 4'd1);
        2'd2:    g = 4'((rl << 1) + rl + 4'd5);
        default: g = 4'((rl << 3) - rl);
      endcase
      return g;
    end
  endfunction

  function automatic logic [31:0] round_fn(input logic [1:0] q, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    begin
      unique case (q)
        2'd0:    f = (b & c) | (~b & d);
        2'd1:    f = (d & b) | (~d & c);
        2'd2:    f = b ^ c ^ d;
        default: f = c ^ (b | ~d);
      endcase
      return f;
    end
  endfunction

endpackage
`default_nettype wire

// ----- hdl/md5_queue.sv -----
// Short beat queue between the input front and the compression back end.
// Depends on md5_pkg.
`default_nettype none
module md5_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  md5_pkg::md5_in_t wr_data_i,
  input  wire             wr_valid_i,
  output logic            wr_ready_o,
  output md5_pkg::md5_in_t rd_data_o,
  output logic            rd_valid_o,
  input  wire             rd_ready_i
);
  import md5_pkg::*;

  md5_in_t    mem_q [QueueDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign wr_ready_o = (count_q != 2'(QueueDepth));
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_valid_i && wr_ready_o) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_valid_i && wr_ready_o) wr_ptr_q <= ~wr_ptr_q;
      if (rd_valid_o && rd_ready_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(wr_valid_i && wr_ready_o) - 2'(rd_valid_o && rd_ready_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 2'(QueueDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0) |-> !(rd_valid_o))
    else $error("read valid with empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_o && !rd_ready_i && !(wr_valid_i && wr_ready_o)) |=> $stable(count_q))
    else $error("queue count moved without a beat");

endmodule
`default_nettype wire

// ----- hdl/md5_core.sv -----
// Back end: block buffer, padding, 64-round compression and result register.
// Depends on md5_pkg.
`default_nettype none
module md5_core (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  md5_pkg::md5_in_t  in_data_i,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  output md5_pkg::md5_out_t out_data_o,
  output logic             out_valid_o,
  input  wire              out_ready_i
);
  import md5_pkg::*;

  md5_bk_state_e state_q, state_d;
  logic [31:0] blk_q [16];
  logic [31:0] ch_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [5:0]  fill_q;
  logic [63:0] len_q;
  logic [5:0]  rnd_q;
  // pad_q: padding already placed; len_blk_q: block holding the length is running.
  logic        pad_q, len_blk_q, fin_q;
  md5_out_t    res_q;
  logic        res_valid_q;

  logic        take;
  logic [31:0] f_w, t_w, rot_w, k_w, m_w;
  logic [4:0]  s_w;
  logic [3:0]  g_w;
  logic [5:0]  fill_inc;

  assign g_w   = word_sel(rnd_q);
  assign k_w   = round_const(rnd_q);
  assign s_w   = rot_amount(rnd_q);
  assign m_w   = blk_q[g_w];
  assign f_w   = round_fn(rnd_q[5:4], b_q, c_q, d_q);
  assign t_w   = f_w + a_q + k_w + m_w;
  assign rot_w = (s_w == 5'd0) ? t_w : ((t_w << s_w) | (t_w >> (6'd32 - {1'b0, s_w})));
  assign fill_inc = fill_q + 6'd1;

  assign in_ready_o  = (state_q == BkIdle) && !res_valid_q;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: begin
        if (take) begin
          if (in_data_i.byte_present && fill_inc == 6'd0) state_d = BkRound;
          else if (in_data_i.last) state_d = BkPad;
        end
      end
      BkRound: begin
        if (rnd_q == 6'd63) begin
          if (len_blk_q) state_d = BkOut;
          else if (fin_q) state_d = BkPad;
          else state_d = BkIdle;
        end
      end
      BkPad:   state_d = BkRound;
      BkOut:   state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BkIdle;
    else         state_q <= state_d;
  end

  // Block buffer has no reset; each byte is written before a round reads it.
  always_ff @(posedge clk_i) begin
    if (state_q == BkIdle && take && in_data_i.byte_present) begin
      unique case (fill_q[1:0])
        2'd0: blk_q[fill_q[5:2]][7:0]   <= in_data_i.data_byte;
        2'd1: blk_q[fill_q[5:2]][15:8]  <= in_data_i.data_byte;
        2'd2: blk_q[fill_q[5:2]][23:16] <= in_data_i.data_byte;
        default: blk_q[fill_q[5:2]][31:24] <= in_data_i.data_byte;
      endcase
    end else if (state_q == BkPad) begin
      for (int w = 0; w < 16; w++) begin
        logic [31:0] nw;
        nw = blk_q[w];
        for (int bb = 0; bb < 4; bb++) begin
          if (pad_q) nw[bb*8 +: 8] = 8'h00;
          else if (6'(w*4+bb) == fill_q) nw[bb*8 +: 8] = PadByte;
          else if (6'(w*4+bb) > fill_q) nw[bb*8 +: 8] = 8'h00;
        end
        if ((pad_q || fill_q < 6'd56) && w == 14) nw = len_q[31:0];
        if ((pad_q || fill_q < 6'd56) && w == 15) nw = len_q[63:32];
        blk_q[w] <= nw;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BkOut) begin
      res_q <= '{digest_a: ch_q[0], digest_b: ch_q[1], digest_c: ch_q[2], digest_d: ch_q[3]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q[0] <= InitA; ch_q[1] <= InitB; ch_q[2] <= InitC; ch_q[3] <= InitD;
      a_q <= InitA; b_q <= InitB; c_q <= InitC; d_q <= InitD;
      fill_q <= '0; len_q <= '0; rnd_q <= '0;
      pad_q <= 1'b0; len_blk_q <= 1'b0; fin_q <= 1'b0; res_valid_q <= 1'b0;
    end else begin
      if (res_valid_q && out_ready_i) res_valid_q <= 1'b0;
      unique case (state_q)
        BkIdle: begin
          if (take) begin
            fin_q <= in_data_i.last;
            if (in_data_i.byte_present) begin
              fill_q <= fill_inc;
              len_q  <= len_q + 64'd8;
            end
          end
          a_q <= ch_q[0]; b_q <= ch_q[1]; c_q <= ch_q[2]; d_q <= ch_q[3];
          rnd_q <= '0;
        end
        BkPad: begin
          len_blk_q <= pad_q || (fill_q < 6'd56);
          pad_q     <= 1'b1;
          a_q <= ch_q[0]; b_q <= ch_q[1]; c_q <= ch_q[2]; d_q <= ch_q[3];
          rnd_q <= '0;
        end
        BkRound: begin
          rnd_q <= rnd_q + 6'd1;
          a_q <= d_q;
          d_q <= c_q;
          c_q <= b_q;
          b_q <= b_q + rot_w;
          if (rnd_q == 6'd63) begin
            ch_q[0] <= ch_q[0] + d_q;
            ch_q[1] <= ch_q[1] + b_q + rot_w;
            ch_q[2] <= ch_q[2] + b_q;
            ch_q[3] <= ch_q[3] + c_q;
            a_q <= ch_q[0] + d_q;
            b_q <= ch_q[1] + b_q + rot_w;
            c_q <= ch_q[2] + b_q;
            d_q <= ch_q[3] + c_q;
          end
        end
        BkOut: begin
          res_valid_q <= 1'b1;
          ch_q[0] <= InitA; ch_q[1] <= InitB; ch_q[2] <= InitC; ch_q[3] <= InitD;
          fill_q <= '0; len_q <= '0; pad_q <= 1'b0; len_blk_q <= 1'b0; fin_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkOut) |=> out_valid_o)
    else $error("digest not presented after final block");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkRound && rnd_q != 6'd63) |=> (state_q == BkRound))
    else $error("compression left early");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(res_q))
    else $error("held digest changed");

endmodule
`default_nettype wire

// ----- hdl/md5_message_digest_unit.sv -----
// Top level of the MD5 digest unit: input queue in front of the compression core.
// Depends on md5_pkg, md5_queue and md5_core.
//
//   Channel   Direction  Beat type   Handshake
//   in        input      md5_in_t    in_valid_i / in_ready_o
//   out       output     md5_out_t   out_valid_o / out_ready_i
//
// A plain byte beat is taken in the idle state; the beat that fills a 64-byte
// block then runs 64 rounds, one at a time on the single shared round unit.
// A last beat adds a padding state and 64 rounds per final block (one or two),
// then the output state loads the digest register.
// The two-entry queue takes up to two beats while the core works or a digest waits.
// Reset is asynchronous and active low; it loads the MD5 initial chaining words.
`default_nettype none
module md5_message_digest_unit (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  md5_pkg::md5_in_t  in_data_i,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  output md5_pkg::md5_out_t out_data_o,
  output logic             out_valid_o,
  input  wire              out_ready_i
);
  import md5_pkg::*;

  md5_in_t q_data;
  logic    q_valid, q_ready;

  // Front: buffer up to two beats while the core compresses a block or holds a digest.
  md5_queue u_queue (
    .clk_i, .rst_ni,
    .wr_data_i(in_data_i), .wr_valid_i(in_valid_i), .wr_ready_o(in_ready_o),
    .rd_data_o(q_data), .rd_valid_o(q_valid), .rd_ready_i(q_ready)
  );

  // Back: packing, padding and the round loop.
  md5_core u_core (
    .clk_i, .rst_ni,
    .in_data_i(q_data), .in_valid_i(q_valid), .in_ready_o(q_ready),
    .out_data_o, .out_valid_o, .out_ready_i
  );

endmodule
`default_nettype wire
